### design/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the round-robin register picker.
// ----------------------------------------------------------------------------
package rrp_pkg;

    // Register file size; indices at or above it count as busy
    localparam int NUM_REGS = 32;
    localparam int REG_W    = 5;
    localparam int MASK_W   = 32;
    localparam int CFG_W    = 3;

    // Command codes carried by a request
    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_FIRST    = 3'd0,
        CFG_LAST     = 3'd1,
        CFG_RESERVED = 3'd2,
        CFG_RESTART  = 3'd3,
        CFG_FALLBACK = 3'd4
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [REG_W-1:0] RST_FIRST    = 5'd1;
    localparam logic [REG_W-1:0] RST_LAST     = 5'd31;
    localparam logic [REG_W-1:0] RST_RESERVED = 5'd15;
    localparam logic [REG_W-1:0] RST_RESTART  = 5'd8;
    localparam logic [REG_W-1:0] RST_FALLBACK = 5'd1;

    // Result of a lowest-set-bit search
    typedef struct packed {
        logic             found;
        logic [REG_W-1:0] pos;
    } t_enc;

endpackage

### design/rrp_in_if.sv
// ----------------------------------------------------------------------------
// rrp_in_if
// Request channel: command and busy mask with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrp_in_if;
    import rrp_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [MASK_W-1:0] busy_mask;

    modport source (output valid, output cmd, output busy_mask, input ready);
    modport sink   (input valid, input cmd, input busy_mask, output ready);

endinterface

### design/rrp_out_if.sv
// ----------------------------------------------------------------------------
// rrp_out_if
// Result channel: picked register and failure flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrp_out_if;
    import rrp_pkg::*;

    logic             valid;
    logic             ready;
    logic [REG_W-1:0] picked_reg;
    logic             failed;

    modport source (output valid, output picked_reg, output failed, input ready);
    modport sink   (input valid, input picked_reg, input failed, output ready);

endinterface

### design/round_robin_reg_picker.sv
// ----------------------------------------------------------------------------
// round_robin_reg_picker
// Round-robin allocator of free registers with a reserved last-resort entry.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: cmd (allocate or restart) and a 32-bit busy mask.
//   o_rsp carries one result per allocate request: picked_reg and failed.
//   A restart request loads the pointer with restart_reg and gives no result.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_wdata) writes first_reg,
//   last_reg, reserved_reg, restart_reg and fallback_reg; other indexes are
//   ignored. Write it only while no request is in flight.
// Timing:
//   A request is registered in the input stage at acceptance; the search
//   (two rotated priority encoders over the registered mask) then loads
//   the result register once that is free. One request per cycle is taken
//   while i_req.ready is high; the pointer updates as it leaves the input stage.
// Reset:
//   Synchronous, active low: config registers take their defaults, the
//   pointer becomes 1 and both stages empty.
// Stall:
//   A held result keeps its value; the input stage holds one more request
//   behind it, then i_req.ready drops. Restart requests drain regardless.
// ----------------------------------------------------------------------------
module round_robin_reg_picker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rrp_pkg::CFG_W-1:0]  i_cfg_idx,
    input  logic [rrp_pkg::REG_W-1:0]  i_cfg_wdata,
    rrp_in_if.sink                     i_req,
    rrp_out_if.source                  o_rsp
);
    import rrp_pkg::*;

    // Lowest set bit of a mask
    function automatic t_enc lsb_find(input logic [MASK_W-1:0] v);
        t_enc res;
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                res.found = 1'b1;
                res.pos   = REG_W'(i);
            end
        end
        return res;
    endfunction

    // Configuration and state
    logic [REG_W-1:0]  r_first, r_last, r_reserved, r_restart, r_fallback;
    logic [REG_W-1:0]  r_ptr, n_ptr;

    // Input stage
    logic              r_in_valid;
    logic              r_cmd;
    logic [MASK_W-1:0] r_mask;

    // Result stage
    logic              r_out_valid;
    logic [REG_W-1:0]  r_picked, n_picked;
    logic              r_failed, n_failed;

    logic              out_free;
    logic              s1_fire;
    logic              s1_alloc;

    logic [MASK_W-1:0] elig, in_a, in_b;
    logic [MASK_W-1:0] rot_a, rot_b;
    logic              first_in_a;
    logic              res_free;
    t_enc              enc_a, enc_b;

    // Handshake
    assign out_free      = !r_out_valid || o_rsp.ready;
    assign s1_fire       = r_in_valid && ((r_cmd == CMD_RESTART) || out_free);
    assign s1_alloc      = s1_fire && (r_cmd == CMD_ALLOC);
    assign i_req.ready   = !r_in_valid || s1_fire;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.picked_reg = r_picked;
    assign o_rsp.failed  = r_failed;

    // Candidate sets: A is the cyclic span pointer..last, B is first..pointer-1
    // unless first already lies in A
    always_comb begin
        logic [REG_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            idx     = REG_W'(i);
            elig[i] = !r_mask[i] && (i < NUM_REGS) && (idx != r_reserved);
            if (r_ptr <= r_last) begin
                in_a[i] = (idx >= r_ptr) && (idx <= r_last);
            end else begin
                in_a[i] = (idx >= r_ptr) || (idx <= r_last);
            end
        end
        if (r_ptr <= r_last) begin
            first_in_a = (r_first >= r_ptr) && (r_first <= r_last);
        end else begin
            first_in_a = (r_first >= r_ptr) || (r_first <= r_last);
        end
        in_b = first_in_a ? '0 : ~in_a;
    end

    // Rotate each set so that its start sits at bit 0, then encode
    always_comb begin
        logic [2*MASK_W-1:0] dbl_a, dbl_b;
        logic [REG_W-1:0]    span_b;
        dbl_a  = {elig & in_a, elig & in_a} >> r_ptr;
        dbl_b  = {elig & in_b, elig & in_b} >> r_first;
        span_b = r_ptr - r_first;
        rot_a  = dbl_a[MASK_W-1:0];
        // B ends just before the pointer
        rot_b  = dbl_b[MASK_W-1:0] & ~({MASK_W{1'b1}} << span_b);
        enc_a  = lsb_find(rot_a);
        enc_b  = lsb_find(rot_b);
    end

    assign res_free = !r_mask[r_reserved] && (int'(r_reserved) < NUM_REGS);

    // Pick, failure flag and pointer update
    always_comb begin
        n_ptr    = r_ptr;
        n_picked = r_fallback;
        n_failed = 1'b1;
        if (enc_a.found) begin
            n_picked = r_ptr + enc_a.pos;
            n_failed = 1'b0;
        end else if (enc_b.found) begin
            n_picked = r_first + enc_b.pos;
            n_failed = 1'b0;
        end else if (res_free) begin
            n_picked = r_reserved;
            n_failed = 1'b0;
        end
        if (s1_fire) begin
            if (r_cmd == CMD_RESTART) begin
                n_ptr = r_restart;
            end else if (enc_a.found || enc_b.found) begin
                n_ptr = (n_picked == r_last) ? r_first : n_picked + 1'b1;
            end
        end
    end

    // Configuration registers and pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= RST_FIRST;
            r_last     <= RST_LAST;
            r_reserved <= RST_RESERVED;
            r_restart  <= RST_RESTART;
            r_fallback <= RST_FALLBACK;
            r_ptr      <= RST_FIRST;
        end else begin
            r_ptr <= n_ptr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST:    r_first    <= i_cfg_wdata;
                    CFG_LAST:     r_last     <= i_cfg_wdata;
                    CFG_RESERVED: r_reserved <= i_cfg_wdata;
                    CFG_RESTART:  r_restart  <= i_cfg_wdata;
                    CFG_FALLBACK: r_fallback <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd  <= i_req.cmd;
            r_mask <= i_req.busy_mask;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_alloc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_alloc) begin
            r_picked <= n_picked;
            r_failed <= n_failed;
        end
    end

`ifndef SYNTHESIS
    // Restart loads the pointer
    a_restart_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_cmd == CMD_RESTART) |=> (r_ptr == $past(r_restart)))
        else $error("pointer not loaded by restart");

    // A failed or reserved pick leaves the pointer alone
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_alloc && !enc_a.found && !enc_b.found) |=> $stable(r_ptr))
        else $error("pointer moved without a round-robin pick");

    // An allocate leaving the input stage always shows up as a result
    a_alloc_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_alloc |=> r_out_valid)
        else $error("allocate result lost");

    // A stuck input stage blocks new requests
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_fire) |-> !i_req.ready)
        else $error("request taken over a stalled one");
`endif

endmodule
